// File: rtl/whtd_pkg.sv
// Shared types and constants for the window hit-test and drag block.
// Used by whtd_hit and window_hit_test_drag; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package whtd_pkg;

    // Operation codes carried in the input tuser.
    localparam logic [1:0] OP_CREATE  = 2'd0;
    localparam logic [1:0] OP_CLICK   = 2'd1;
    localparam logic [1:0] OP_MOVE    = 2'd2;
    localparam logic [1:0] OP_RELEASE = 2'd3;

    // Status codes carried in the output tuser.
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    localparam logic [3:0] NO_ACTIVE   = 4'd8;
    localparam logic [7:0] TBH_RESET   = 8'd20;
    localparam logic [2:0] DRAG_BUTTON = 3'd1;

    typedef struct packed {
        logic hit;
        logic in_title;
    } hit_t;

    // Clamp a 17-bit signed difference to the 16-bit signed range.
    function automatic logic [15:0] sat16(input logic [16:0] v);
        logic [15:0] r;
        if (v[16] != v[15])
        begin
            r = v[16] ? 16'h8000 : 16'h7fff;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/window_hit_test_drag.sv
// Top level of the window hit-test and drag block: sequencer, window table
// memory and result register. Depends on whtd_pkg and whtd_hit.
//
// Usage: one input transfer on the s_ channel carries an event (create,
// click, move, release); exactly one result transfer follows on the m_
// channel. title_bar_height is written through cfg_we/cfg_wdata while idle.
// Create, move and release run in the S_EXEC state, which registers
// the result and m_tvalid. A click examines the windows from the topmost
// down; one shared hit-test unit checks one window per pass through the
// S_READ and S_CHECK states, paced by the registered table memory read.
// The block handles one event at a time: s_tready is low from the input
// transfer until the result has been taken, so a stalled receiver holds
// the result in the output register and the input side waits.
// Reset clears the window count, the drag state and the active window
// (none), and loads title_bar_height with 20. Table entries need no
// clearing since only entries below the window count are read.
`timescale 1ns / 1ps
`default_nettype none

module window_hit_test_drag
    import whtd_pkg::*;
#(
    parameter int WINDOW_SLOTS = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration: title_bar_height.
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,
    // Input events.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // pos_x[15:0], pos_y[31:16], size_w[46:32], size_h[61:47], button[64:62]
    input  wire logic [71:0] s_tdata,
    // operation[1:0]
    input  wire logic [1:0]  s_tuser,
    // Results.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // window_index[2:0], active_index[6:3], dragging[7], new_x[23:8], new_y[39:24]
    output logic [39:0]      m_tdata,
    // status[1:0]
    output logic [1:0]       m_tuser
);

    localparam int IDX_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
    localparam int CNT_W = $clog2(WINDOW_SLOTS + 1);
    localparam int XW    = IDX_W + 4;
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(WINDOW_SLOTS);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_CHECK = 2'd3;

    // Window table: {top, left} and {height, width}.
    logic [31:0] pos_mem  [WINDOW_SLOTS];
    logic [29:0] size_mem [WINDOW_SLOTS];

    logic [1:0]       state_reg,       state_next;
    logic [CNT_W-1:0] count_reg,       count_next;
    logic [XW-1:0]    active_reg,      active_next;
    logic [IDX_W-1:0] drag_slot_reg,   drag_slot_next;
    logic             drag_active_reg, drag_active_next;
    logic [15:0]      off_x_reg,       off_x_next;
    logic [15:0]      off_y_reg,       off_y_next;
    logic [IDX_W-1:0] scan_reg,        scan_next;
    logic [7:0]       tbh_reg;
    logic             m_valid_reg,     m_valid_next;
    logic [1:0]       o_status_reg,    o_status_next;
    logic [IDX_W-1:0] o_widx_reg,      o_widx_next;
    logic [15:0]      o_nx_reg,        o_nx_next;
    logic [15:0]      o_ny_reg,        o_ny_next;

    logic [1:0]  op_reg;
    logic [15:0] px_reg;
    logic [15:0] py_reg;
    logic [14:0] sw_reg;
    logic [14:0] sh_reg;
    logic [2:0]  btn_reg;
    logic [31:0] rd_pos_reg;
    logic [29:0] rd_size_reg;

    logic             accept;
    logic             wr_en;
    logic             wr_size_en;
    logic [IDX_W-1:0] wr_addr;
    logic [31:0]      wr_pos;
    logic [16:0]      diff_x;
    logic [16:0]      diff_y;
    logic [15:0]      sat_x;
    logic [15:0]      sat_y;
    hit_t             hit_res;
    logic [XW-1:0]    widx_ext;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE) && !m_valid_reg;

    whtd_hit u_hit (
        .px     (px_reg),
        .py     (py_reg),
        .left   (rd_pos_reg[15:0]),
        .top    (rd_pos_reg[31:16]),
        .width  (rd_size_reg[14:0]),
        .height (rd_size_reg[29:15]),
        .tbh    (tbh_reg),
        .res    (hit_res)
    );

    // Pointer minus grab offset; offsets are never negative.
    assign diff_x = {px_reg[15], px_reg} - {1'b0, off_x_reg};
    assign diff_y = {py_reg[15], py_reg} - {1'b0, off_y_reg};
    assign sat_x  = sat16(diff_x);
    assign sat_y  = sat16(diff_y);

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        active_next      = active_reg;
        drag_slot_next   = drag_slot_reg;
        drag_active_next = drag_active_reg;
        off_x_next       = off_x_reg;
        off_y_next       = off_y_reg;
        scan_next        = scan_reg;
        m_valid_next     = m_valid_reg;
        o_status_next    = o_status_reg;
        o_widx_next      = o_widx_reg;
        o_nx_next        = o_nx_reg;
        o_ny_next        = o_ny_reg;
        wr_en            = 1'b0;
        wr_size_en       = 1'b0;
        wr_addr          = count_reg[IDX_W-1:0];
        wr_pos           = {py_reg, px_reg};

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next    = S_IDLE;
                m_valid_next  = 1'b1;
                o_status_next = ST_DONE;
                o_widx_next   = '0;
                o_nx_next     = '0;
                o_ny_next     = '0;
                case (op_reg)
                    OP_CREATE:
                    begin
                        if (count_reg == SLOTS_C)
                        begin
                            o_status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_en       = 1'b1;
                            wr_size_en  = 1'b1;
                            active_next = XW'(count_reg);
                            o_widx_next = count_reg[IDX_W-1:0];
                            count_next  = count_reg + CNT_W'(1);
                        end
                    end
                    OP_CLICK:
                    begin
                        if (count_reg == '0)
                        begin
                            o_status_next = ST_MISS;
                        end
                        else
                        begin
                            m_valid_next = 1'b0;
                            scan_next    = IDX_W'(count_reg - CNT_W'(1));
                            state_next   = S_READ;
                        end
                    end
                    OP_MOVE:
                    begin
                        if (drag_active_reg)
                        begin
                            wr_en       = 1'b1;
                            wr_addr     = drag_slot_reg;
                            wr_pos      = {sat_y, sat_x};
                            o_widx_next = drag_slot_reg;
                            o_nx_next   = sat_x;
                            o_ny_next   = sat_y;
                        end
                        else
                        begin
                            o_status_next = ST_MISS;
                        end
                    end
                    default:
                    begin
                        drag_active_next = 1'b0;
                    end
                endcase
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            default:
            begin
                // One window checked per visit, topmost first.
                if (hit_res.hit)
                begin
                    state_next    = S_IDLE;
                    m_valid_next  = 1'b1;
                    o_status_next = ST_DONE;
                    o_widx_next   = scan_reg;
                    active_next   = XW'(scan_reg);
                    if (hit_res.in_title && (btn_reg == DRAG_BUTTON))
                    begin
                        drag_slot_next   = scan_reg;
                        drag_active_next = 1'b1;
                        off_x_next       = px_reg - rd_pos_reg[15:0];
                        off_y_next       = py_reg - rd_pos_reg[31:16];
                    end
                end
                else if (scan_reg == '0)
                begin
                    state_next    = S_IDLE;
                    m_valid_next  = 1'b1;
                    o_status_next = ST_MISS;
                    o_widx_next   = '0;
                end
                else
                begin
                    scan_next  = scan_reg - IDX_W'(1);
                    state_next = S_READ;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            active_reg      <= XW'(NO_ACTIVE);
            drag_slot_reg   <= '0;
            drag_active_reg <= 1'b0;
            off_x_reg       <= '0;
            off_y_reg       <= '0;
            scan_reg        <= '0;
            tbh_reg         <= TBH_RESET;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            active_reg      <= active_next;
            drag_slot_reg   <= drag_slot_next;
            drag_active_reg <= drag_active_next;
            off_x_reg       <= off_x_next;
            off_y_reg       <= off_y_next;
            scan_reg        <= scan_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_we)
            begin
                tbh_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= s_tuser;
            px_reg  <= s_tdata[15:0];
            py_reg  <= s_tdata[31:16];
            sw_reg  <= s_tdata[46:32];
            sh_reg  <= s_tdata[61:47];
            btn_reg <= s_tdata[64:62];
        end
        o_status_reg <= o_status_next;
        o_widx_reg   <= o_widx_next;
        o_nx_reg     <= o_nx_next;
        o_ny_reg     <= o_ny_next;
    end

    // Table memory: one write port, one registered read port for the scan.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pos_mem[wr_addr] <= wr_pos;
            if (wr_size_en)
            begin
                size_mem[wr_addr] <= {sh_reg, sw_reg};
            end
        end
        rd_pos_reg  <= pos_mem[scan_reg];
        rd_size_reg <= size_mem[scan_reg];
    end

    assign widx_ext = XW'(o_widx_reg);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_status_reg;
    assign m_tdata  = {o_ny_reg, o_nx_reg, drag_active_reg,
                       active_reg[3:0], widx_ext[2:0]};

    // A result waiting for the receiver blocks new events.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> !s_tready)
        else $error("input accepted while a result is pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= SLOTS_C)
        else $error("window count exceeds table size");

    assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg == XW'(NO_ACTIVE)) || (active_reg < XW'(count_reg)))
        else $error("active window outside the table");

    assert property (@(posedge clk) disable iff (!rst_n)
        drag_active_reg |-> (XW'(drag_slot_reg) < XW'(count_reg)))
        else $error("dragged window outside the table");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC) && !m_valid_reg)
        else $error("accepted event not executed");

endmodule

`default_nettype wire

// File: rtl/whtd_hit.sv
// Point-in-rectangle test for one window, plus the title strip test.
// Reused for every window of a click scan; depends on whtd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module whtd_hit
    import whtd_pkg::*;
(
    input  wire logic [15:0] px,
    input  wire logic [15:0] py,
    input  wire logic [15:0] left,
    input  wire logic [15:0] top,
    input  wire logic [14:0] width,
    input  wire logic [14:0] height,
    input  wire logic [7:0]  tbh,
    output hit_t             res
);

    logic signed [16:0] px_s;
    logic signed [16:0] py_s;
    logic signed [16:0] left_s;
    logic signed [16:0] top_s;
    logic signed [16:0] right_s;
    logic signed [16:0] bottom_s;
    logic signed [16:0] title_s;

    // Edges fit in 17 signed bits: at most 32767 + 32767.
    assign px_s     = $signed({px[15], px});
    assign py_s     = $signed({py[15], py});
    assign left_s   = $signed({left[15], left});
    assign top_s    = $signed({top[15], top});
    assign right_s  = left_s + $signed({2'b00, width});
    assign bottom_s = top_s + $signed({2'b00, height});
    assign title_s  = top_s + $signed({9'd0, tbh});

    assign res.hit = (px_s >= left_s) && (px_s < right_s)
                  && (py_s >= top_s) && (py_s < bottom_s);
    assign res.in_title = (py_s < title_s);

endmodule

`default_nettype wire

// File: verif/window_hit_test_drag_test.sv
// Self-checking testbench for window_hit_test_drag: a directed table of events
// followed by random event streams, checked against a behavioral window table.
// Depends on whtd_pkg and the window_hit_test_drag RTL.
`timescale 1ns / 1ps

module window_hit_test_drag_test
    import whtd_pkg::*;
();

    localparam int SLOTS = 8;
    localparam int DIRECTED_ROWS = 25;
    localparam int PHASES = 5;
    localparam int PHASE_EVENTS = 380;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 30;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
        logic [2:0]         btn;
    } pointer_event_t;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] win;
        logic [3:0] act;
        logic       drag;
    } brief_t;

    typedef struct packed {
        brief_t      head;
        logic [15:0] nx;
        logic [15:0] ny;
    } outcome_t;

    typedef struct packed {
        pointer_event_t ev;
        logic           typed;
        brief_t         want;
    } row_t;

    // Typed rows expect zero for new_x and new_y.
    localparam row_t DIRECTED [DIRECTED_ROWS] = '{
        '{'{OP_MOVE, 16'sd0, 16'sd0, 15'd0, 15'd0, 3'd1}, 1'b1, '{ST_MISS, 3'd0, NO_ACTIVE, 1'b0}},
        '{'{OP_RELEASE, 16'sd0, 16'sd0, 15'd0, 15'd0, 3'd0}, 1'b1,
            '{ST_DONE, 3'd0, NO_ACTIVE, 1'b0}},
        '{'{OP_CLICK, 16'sd0, 16'sd0, 15'd0, 15'd0, 3'd1}, 1'b1, '{ST_MISS, 3'd0, NO_ACTIVE, 1'b0}},
        '{'{OP_CREATE, 16'sh8000, 16'sh8000, 15'h7fff, 15'h7fff, 3'd0}, 1'b1,
            '{ST_DONE, 3'd0, 4'd0, 1'b0}},
        '{'{OP_CREATE, 16'sh7fff, 16'sh7fff, 15'h7fff, 15'h7fff, 3'd7}, 1'b1,
            '{ST_DONE, 3'd1, 4'd1, 1'b0}},
        '{'{OP_CREATE, 16'sd100, 16'sd100, 15'd0, 15'd50, 3'd0}, 1'b1,
            '{ST_DONE, 3'd2, 4'd2, 1'b0}},
        '{'{OP_CREATE, 16'sd100, 16'sd100, 15'd50, 15'd0, 3'd0}, 1'b1,
            '{ST_DONE, 3'd3, 4'd3, 1'b0}},
        '{'{OP_CREATE, 16'sd0, 16'sd0, 15'd200, 15'd10, 3'd0}, 1'b1, '{ST_DONE, 3'd4, 4'd4, 1'b0}},
        '{'{OP_CREATE, 16'sd300, 16'sd300, 15'd400, 15'd300, 3'd0}, 1'b1,
            '{ST_DONE, 3'd5, 4'd5, 1'b0}},
        '{'{OP_CLICK, 16'sd100, 16'sd100, 15'd0, 15'd0, 3'd1}, 1'b0, '0},
        '{'{OP_CLICK, 16'sd5, 16'sd5, 15'd0, 15'd0, 3'd1}, 1'b0, '0},
        '{'{OP_CLICK, 16'sd5, 16'sd5, 15'd0, 15'd0, 3'd2}, 1'b0, '0},
        '{'{OP_CLICK, 16'sd310, 16'sd305, 15'd0, 15'd0, 3'd0}, 1'b0, '0},
        '{'{OP_CREATE, -16'sd50, -16'sd50, 15'd100, 15'd100, 3'd0}, 1'b0, '0},
        '{'{OP_MOVE, 16'sd20, 16'sd30, 15'd0, 15'd0, 3'd0}, 1'b0, '0},
        '{'{OP_CLICK, 16'sd310, 16'sd305, 15'd0, 15'd0, 3'd1}, 1'b0, '0},
        '{'{OP_CLICK, 16'sd310, 16'sd400, 15'd0, 15'd0, 3'd1}, 1'b0, '0},
        '{'{OP_MOVE, 16'sh8000, 16'sh8000, 15'd0, 15'd0, 3'd0}, 1'b0, '0},
        '{'{OP_CLICK, 16'sh7fff, 16'sh7fff, 15'd0, 15'd0, 3'd1}, 1'b0, '0},
        '{'{OP_MOVE, 16'sh7fff, 16'sh7fff, 15'd0, 15'd0, 3'd0}, 1'b0, '0},
        '{'{OP_RELEASE, 16'sd0, 16'sd0, 15'd0, 15'd0, 3'd0}, 1'b0, '0},
        '{'{OP_CREATE, 16'sd1000, 16'sd1000, 15'd1, 15'd1, 3'd0}, 1'b1,
            '{ST_DONE, 3'd7, 4'd7, 1'b0}},
        '{'{OP_CREATE, 16'sd5, 16'sd5, 15'd5, 15'd5, 3'd0}, 1'b1, '{ST_FULL, 3'd0, 4'd7, 1'b0}},
        '{'{OP_MOVE, 16'sd1, 16'sd1, 15'd0, 15'd0, 3'd0}, 1'b1, '{ST_MISS, 3'd0, 4'd7, 1'b0}},
        '{'{OP_CLICK, 16'sd1000, 16'sd1000, 15'd0, 15'd0, 3'd7}, 1'b0, '0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = 8'd0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [71:0] s_tdata = 72'd0;
    logic [1:0]  s_tuser = 2'd0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire [39:0]  m_tdata;
    wire [1:0]   m_tuser;

    window_hit_test_drag #(.WINDOW_SLOTS(SLOTS)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Behavioral copy of the window table and drag state.
    int win_left [SLOTS];
    int win_top [SLOTS];
    int win_w [SLOTS];
    int win_h [SLOTS];
    int win_count = 0;
    int focus_slot = NO_ACTIVE;
    int grab_slot = 0;
    bit grabbing = 1'b0;
    int grab_dx = 0;
    int grab_dy = 0;
    int strip_height = TBH_RESET;

    outcome_t awaited_outcomes[$];
    bit       calm = 1'b0;
    int       errors = 0;
    int       reported = 0;
    int       results_checked = 0;
    int       events_sent = 0;
    int       drags_started = 0;
    int       quiet_cycles = 0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic int clamp_s16(input int v);
        if (v > 32767)
        begin
            return 32767;
        end
        if (v < -32768)
        begin
            return -32768;
        end
        return v;
    endfunction

    function automatic outcome_t window_table_step(input pointer_event_t ev);
        outcome_t r;
        int px;
        int py;
        int k;
        bit hit;
        r = '0;
        px = $signed(ev.x);
        py = $signed(ev.y);
        hit = 1'b0;
        case (ev.op)
            OP_CREATE:
            begin
                if (win_count >= SLOTS)
                begin
                    r.head.status = ST_FULL;
                end
                else
                begin
                    win_left[win_count] = px;
                    win_top[win_count] = py;
                    win_w[win_count] = int'(ev.w);
                    win_h[win_count] = int'(ev.h);
                    focus_slot = win_count;
                    r.head.win = 3'(win_count);
                    win_count++;
                end
            end
            OP_CLICK:
            begin
                // Topmost window first; empty windows can never hold the point.
                for (k = win_count - 1; k >= 0 && !hit; k--)
                begin
                    if (px >= win_left[k] && px < win_left[k] + win_w[k] &&
                        py >= win_top[k] && py < win_top[k] + win_h[k])
                    begin
                        hit = 1'b1;
                        focus_slot = k;
                        r.head.win = 3'(k);
                        if (py < win_top[k] + strip_height && ev.btn == DRAG_BUTTON)
                        begin
                            grab_slot = k;
                            grabbing = 1'b1;
                            grab_dx = px - win_left[k];
                            grab_dy = py - win_top[k];
                            drags_started++;
                        end
                    end
                end
                if (!hit)
                begin
                    r.head.status = ST_MISS;
                end
            end
            OP_MOVE:
            begin
                if (grabbing)
                begin
                    win_left[grab_slot] = clamp_s16(px - grab_dx);
                    win_top[grab_slot] = clamp_s16(py - grab_dy);
                    r.nx = 16'(win_left[grab_slot]);
                    r.ny = 16'(win_top[grab_slot]);
                    r.head.win = 3'(grab_slot);
                end
                else
                begin
                    r.head.status = ST_MISS;
                end
            end
            default:
            begin
                grabbing = 1'b0;
            end
        endcase
        r.head.act = 4'(focus_slot);
        r.head.drag = grabbing;
        return r;
    endfunction

    // Mostly clicks aimed at live windows (often in the title strip with the
    // drag button), moves near the grabbed window and releases; the rest is noise.
    function automatic pointer_event_t random_event();
        pointer_event_t ev;
        int roll;
        int k;
        int tries;
        int lim;
        int px;
        int py;
        ev.op = 2'($urandom);
        ev.x = 16'($urandom);
        ev.y = 16'($urandom);
        ev.w = 15'($urandom);
        ev.h = 15'($urandom);
        ev.btn = 3'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 45)
        begin
            ev.op = OP_CLICK;
            k = -1;
            for (tries = 0; tries < 8 && k < 0 && win_count > 0; tries++)
            begin
                k = $urandom_range(0, win_count - 1);
                if (win_w[k] == 0 || win_h[k] == 0)
                begin
                    k = -1;
                end
            end
            if (k >= 0)
            begin
                lim = (win_h[k] < strip_height) ? win_h[k] : strip_height;
                px = win_left[k] + int'($urandom_range(0, win_w[k] - 1));
                if (lim > 0 && $urandom_range(0, 9) < 6)
                begin
                    py = win_top[k] + int'($urandom_range(0, lim - 1));
                end
                else
                begin
                    py = win_top[k] + int'($urandom_range(0, win_h[k] - 1));
                end
                ev.x = 16'(clamp_s16(px));
                ev.y = 16'(clamp_s16(py));
                ev.btn = ($urandom_range(0, 9) < 7) ? DRAG_BUTTON : 3'($urandom);
            end
        end
        else if (roll < 75)
        begin
            ev.op = OP_MOVE;
            if (grabbing && $urandom_range(0, 9) < 7)
            begin
                px = win_left[grab_slot] + grab_dx + int'($urandom_range(0, 600)) - 300;
                py = win_top[grab_slot] + grab_dy + int'($urandom_range(0, 600)) - 300;
                ev.x = 16'(clamp_s16(px));
                ev.y = 16'(clamp_s16(py));
            end
        end
        else if (roll < 85)
        begin
            ev.op = OP_RELEASE;
        end
        else if (roll < 90)
        begin
            ev.op = OP_CREATE;
        end
        return ev;
    endfunction

    task automatic deliver(input pointer_event_t ev, input bit typed, input brief_t want);
        outcome_t predicted;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, ev.btn, ev.h, ev.w, ev.y, ev.x};
        s_tuser <= ev.op;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predicted = window_table_step(ev);
        if (typed)
        begin
            predicted = {want, 32'd0};
        end
        awaited_outcomes.push_back(predicted);
        events_sent++;
    endtask

    task automatic maybe_pause();
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17) - 1) @(negedge clk);
        end
    endtask

    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (awaited_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic load_strip_height(input logic [7:0] v);
        settle();
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        strip_height = v;
    endtask

    // Receiver: random stall bursts, none once the run turns calm.
    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                hold--;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                hold = $urandom_range(1, 17) - 1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        if (m_tvalid && m_tready)
        begin
            got = {m_tuser, m_tdata[2:0], m_tdata[6:3], m_tdata[7], m_tdata[23:8],
                m_tdata[39:24]};
            if (awaited_outcomes.size() == 0)
            begin
                errors++;
                if (reported < REPORT_LIMIT)
                begin
                    reported++;
                    $display("%0t: result transfer with nothing awaited: status %0d data %h",
                        $time, m_tuser, m_tdata);
                end
            end
            else
            begin
                want = awaited_outcomes.pop_front();
                results_checked++;
                if (got !== want)
                begin
                    errors++;
                    if (reported < REPORT_LIMIT)
                    begin
                        reported++;
                        $display("%0t: expected st %0d win %0d act %0d drag %0d x %0d y %0d",
                            $time, want.head.status, want.head.win, want.head.act,
                            want.head.drag, $signed(want.nx), $signed(want.ny));
                        $display("%0t: actual   st %0d win %0d act %0d drag %0d x %0d y %0d",
                            $time, got.head.status, got.head.win, got.head.act,
                            got.head.drag, $signed(got.nx), $signed(got.ny));
                    end
                end
            end
        end
    end

    // Watchdog: too many cycles in a row without any transfer ends the run.
    always @(posedge clk)
    begin
        if (rst_n && !((s_tvalid && s_tready) || (m_tvalid && m_tready)))
        begin
            quiet_cycles++;
        end
        else
        begin
            quiet_cycles = 0;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("window_hit_test_drag_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        pointer_event_t ev;
        logic [7:0] strips [PHASES];
        int p;
        int i;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            maybe_pause();
            deliver(DIRECTED[i].ev, DIRECTED[i].typed, DIRECTED[i].want);
        end

        strips = '{8'd0, 8'd255, 8'd1, 8'($urandom_range(2, 254)), TBH_RESET};
        for (p = 0; p < PHASES; p++)
        begin
            load_strip_height(strips[p]);
            calm = (p == PHASES - 1);
            for (i = 0; i < PHASE_EVENTS; i++)
            begin
                if ($urandom_range(0, 149) == 0)
                begin
                    settle();
                end
                maybe_pause();
                ev = random_event();
                deliver(ev, 1'b0, '0);
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (awaited_outcomes.size() != 0)
        begin
            errors += awaited_outcomes.size();
            $display("%0d results never arrived", awaited_outcomes.size());
        end
        $display("Sent %0d events (create, click, move, release) with title strip heights 20, 0,",
            events_sent);
        $display("255, 1, %0d and 20; %0d drags started, %0d results compared, %0d failures.",
            strips[3], drags_started, results_checked, errors);
        if (errors == 0)
        begin
            $display("window_hit_test_drag_test: done, clean");
        end
        else
        begin
            $display("window_hit_test_drag_test: done, errors");
        end
        $finish;
    end

endmodule
